[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

[design/cst_pkg.sv]
`timescale 1ns / 1ps

package cst_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] BOM_B0   = 8'hEF;
  localparam logic [7:0] BOM_B1   = 8'hBB;
  localparam logic [7:0] BOM_B2   = 8'hBF;

  localparam int MAX_RES = 3;

  typedef enum logic [1:0] {
    KIND_CONTENT   = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_ROW_END   = 2'd2
  } kind_t;

  typedef logic [1:0] rcount_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       blank;
  } result_t;

  typedef struct packed {
    rcount_t                   count;
    result_t [MAX_RES-1:0]     res;
  } bundle_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

[design/cst_fifo.sv]
`timescale 1ns / 1ps

module cst_fifo
  import cst_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  input  bundle_t push_data,
  output logic    push_ready,
  output hs_t     pop_hs,
  input  logic    pop,
  output bundle_t pop_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  bundle_t         mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push;
  logic            do_pop;

  assign push_ready   = (cnt_r != CW'(DEPTH));
  assign pop_hs.valid = (cnt_r != '0);
  assign pop_hs.ready = pop;
  assign pop_data     = mem_r[rd_ptr_r];
  assign do_push      = push_valid && push_ready;
  assign do_pop       = pop && pop_hs.valid;

  function automatic logic [AW-1:0] advance(logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= advance(wr_ptr_r);
      if (do_pop) rd_ptr_r <= advance(rd_ptr_r);
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

[design/cst_front.sv]
`timescale 1ns / 1ps

module cst_front
  import cst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_action,
  input  logic [7:0] in_data_byte,
  output logic       push_valid,
  output bundle_t    push_data,
  input  logic       push_ready
);

  typedef enum logic [1:0] {
    PM_UNQUOTED   = 2'd0,
    PM_QUOTED     = 2'd1,
    PM_QUOTE_SEEN = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    BOM_WAIT0 = 2'd0,
    BOM_HELD1 = 2'd1,
    BOM_HELD2 = 2'd2,
    BOM_DONE  = 2'd3
  } bom_t;

  typedef struct packed {
    mode_t mode;
    logic  field_started;
    logic  row_started;
    logic  row_has_content;
  } tok_t;

  typedef struct packed {
    tok_t    st;
    logic    emit;
    result_t res;
  } feed_t;

  localparam tok_t TOK_RESET = '{mode: PM_UNQUOTED, default: 1'b0};

  tok_t    tok_r, tok_nxt, rep_st;
  bom_t    bom_r, bom_nxt;
  feed_t   fa, fb, fc, fe;
  bundle_t rep, bund;
  logic    mark_match;
  logic    accept;

  function automatic logic is_blank(logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
  endfunction

  function automatic feed_t start(tok_t s);
    feed_t f;
    f.st   = s;
    f.emit = 1'b0;
    f.res  = '0;
    return f;
  endfunction

  function automatic feed_t append(feed_t fi, logic [7:0] c);
    feed_t f;
    f               = fi;
    f.emit          = 1'b1;
    f.res.kind      = KIND_CONTENT;
    f.res.data      = c;
    f.res.blank     = 1'b0;
    f.st.field_started = 1'b1;
    if (!is_blank(c)) f.st.row_has_content = 1'b1;
    return f;
  endfunction

  function automatic feed_t end_row(feed_t fi);
    feed_t f;
    f                    = fi;
    f.emit               = 1'b1;
    f.res.kind           = KIND_ROW_END;
    f.res.data           = '0;
    f.res.blank          = !fi.st.row_has_content;
    f.st.field_started   = 1'b0;
    f.st.row_started     = 1'b0;
    f.st.row_has_content = 1'b0;
    return f;
  endfunction

  function automatic feed_t feed(tok_t s, logic [7:0] c);
    feed_t f;
    logic  go_unq;
    f      = start(s);
    go_unq = 1'b0;
    case (s.mode)
      PM_QUOTE_SEEN: begin
        if (c == CH_QUOTE) begin
          f         = append(f, c);
          f.st.mode = PM_QUOTED;
        end else begin
          go_unq = 1'b1;
        end
      end
      PM_QUOTED: begin
        if (c == CH_QUOTE) f.st.mode = PM_QUOTE_SEEN;
        else f = append(f, c);
      end
      default: go_unq = 1'b1;
    endcase
    if (go_unq) begin
      f.st.mode = PM_UNQUOTED;
      case (c)
        CH_QUOTE: f.st.mode = PM_QUOTED;
        CH_COMMA: begin
          f.emit             = 1'b1;
          f.res.kind         = KIND_FIELD_END;
          f.res.data         = '0;
          f.res.blank        = 1'b0;
          f.st.row_started   = 1'b1;
          f.st.field_started = 1'b0;
        end
        CH_CR: ;
        CH_LF: f = end_row(f);
        default: f = append(f, c);
      endcase
    end
    return f;
  endfunction

  function automatic bundle_t add(bundle_t bi, feed_t f);
    bundle_t b;
    b = bi;
    if (f.emit) begin
      b.res[b.count] = f.res;
      b.count        = b.count + 2'd1;
    end
    return b;
  endfunction

  always_comb begin
    fa     = feed(tok_r, BOM_B0);
    fb     = feed(fa.st, BOM_B1);
    rep    = '0;
    rep_st = tok_r;
    if (bom_r == BOM_HELD1) begin
      rep    = add(rep, fa);
      rep_st = fa.st;
    end else if (bom_r == BOM_HELD2) begin
      rep    = add(add(rep, fa), fb);
      rep_st = fb.st;
    end
    fc = feed(rep_st, in_data_byte);
    fe = end_row(start(rep_st));

    mark_match = ((bom_r == BOM_WAIT0) && (in_data_byte == BOM_B0)) ||
                 ((bom_r == BOM_HELD1) && (in_data_byte == BOM_B1)) ||
                 ((bom_r == BOM_HELD2) && (in_data_byte == BOM_B2));

    bund    = rep;
    tok_nxt = tok_r;
    bom_nxt = bom_r;
    if (in_action) begin
      if (rep_st.field_started || rep_st.row_started) bund = add(rep, fe);
      tok_nxt = TOK_RESET;
      bom_nxt = BOM_WAIT0;
    end else if (mark_match) begin
      bund    = '0;
      bom_nxt = bom_t'(bom_r + 2'd1);
    end else begin
      bund    = add(rep, fc);
      tok_nxt = fc.st;
      bom_nxt = BOM_DONE;
    end
  end

  assign in_ready   = push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = in_valid && (bund.count != '0);
  assign push_data  = bund;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= TOK_RESET;
      bom_r <= BOM_WAIT0;
    end else if (accept) begin
      tok_r <= tok_nxt;
      bom_r <= bom_nxt;
    end
  end

endmodule

[design/cst_back.sv]
`timescale 1ns / 1ps

module cst_back
  import cst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  hs_t        pop_hs,
  output logic       pop,
  input  bundle_t    head,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_content_byte,
  output logic       out_row_blank,
  output logic       out_last
);

  logic    out_valid_r;
  result_t out_res_r;
  logic    out_last_r;
  rcount_t idx_r, idx_nxt;
  logic    load;
  logic    cur_last;

  assign load     = pop_hs.valid && (!out_valid_r || out_ready);
  assign cur_last = (idx_r == head.count - 2'd1);
  assign pop      = load && cur_last;
  assign idx_nxt  = cur_last ? '0 : idx_r + 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      idx_r       <= idx_nxt;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r  <= head.res[idx_r];
      out_last_r <= cur_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_res_r.kind;
  assign out_content_byte = out_res_r.data;
  assign out_row_blank    = out_res_r.blank;
  assign out_last         = out_last_r;

endmodule

[design/csv_stream_tokenizer.sv]
// CSV stream tokenizer.
// Input channel (in_valid/in_ready): one transaction per raw byte, in_action 0,
// or an end-of-input marker, in_action 1, that flushes a pending row and
// restarts the parser, including byte-order-mark detection.
// Output channel (out_valid/out_ready): one transaction per token: a content
// byte, a field end or a row end with its blank flag. out_last marks the final
// token caused by one input transaction; a byte may cause none and up to three.
// Path: the front classifies a byte in the cycle it is accepted and writes
// its tokens into a FIFO_DEPTH-entry queue; the output register then loads
// them from the queue head one token at a time.
// Throughput: one input byte per cycle while the queue has room; the output
// register drains one token per cycle while out_ready is high.
// Stall: while out_ready is low the token holds; the queue keeps taking input
// until it is full, then in_ready drops.
// Reset (rst_n low, synchronous): the queue and output register empty, the
// parser returns to unquoted mode, awaiting a byte-order mark.
`timescale 1ns / 1ps

module csv_stream_tokenizer
  import cst_pkg::*;
#(
  parameter int FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_action,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_content_byte,
  output logic       out_row_blank,
  output logic       out_last
);

  logic    push_valid;
  logic    push_ready;
  bundle_t push_data;
  hs_t     pop_hs;
  logic    pop;
  bundle_t head;

  cst_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_data_byte (in_data_byte),
    .push_valid   (push_valid),
    .push_data    (push_data),
    .push_ready   (push_ready)
  );

  cst_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_hs     (pop_hs),
    .pop        (pop),
    .pop_data   (head)
  );

  cst_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_hs           (pop_hs),
    .pop              (pop),
    .head             (head),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_content_byte (out_content_byte),
    .out_row_blank    (out_row_blank),
    .out_last         (out_last)
  );

endmodule

[design/cst_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cst_checker
  import cst_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_content_byte,
  input logic       out_row_blank,
  input logic       out_last
);

  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_content_byte) && $stable(out_row_blank) && $stable(out_last), "stalled token changed")
  `ASSERT_IMPL(a_marker_no_data, out_valid && (out_kind != KIND_CONTENT), out_content_byte == 8'd0, "marker carries data")
  `ASSERT_IMPL(a_blank_on_row_end, out_valid && (out_kind != KIND_ROW_END), !out_row_blank, "blank flag off row end")
  `ASSERT_IMPL(a_row_end_last, out_valid && (out_kind == KIND_ROW_END), out_last, "row end not last of transaction")

endmodule

bind csv_stream_tokenizer cst_checker u_cst_checker (.*);

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import cst_pkg::*;

  localparam int RAND_ITEMS = 500;
  localparam int LONG_HOLD  = 60;
  localparam int NUM_ROWS   = 28;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       blank;
    logic       last;
  } token_t;

  typedef struct packed {
    logic       act;
    logic [7:0] c;
    bit         typed;
    bit         n;
    kind_t      kind;
    logic [7:0] d;
    logic       blank;
  } row_t;

  typedef enum logic [1:0] {
    PM_PLAIN      = 2'd0,
    PM_QUOTED     = 2'd1,
    PM_QUOTE_SEEN = 2'd2
  } pmode_t;

  typedef enum logic [1:0] {
    BOM_IDLE      = 2'd0,
    BOM_HELD_EF   = 2'd1,
    BOM_HELD_EFBB = 2'd2,
    BOM_DONE      = 2'd3
  } bom_t;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_action    = 1'b0;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_ready    = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [1:0] out_kind;
  logic [7:0] out_content_byte;
  logic       out_row_blank;
  logic       out_last;

  token_t tokens_due[$];
  token_t step_toks[$];

  pmode_t pmode;
  bom_t   bom_ph;
  logic   fld_open;
  logic   row_open;
  logic   row_nonblank;

  int mismatches = 0;
  int items_sent = 0;
  bit idle_on    = 1'b1;
  bit hold_req   = 1'b0;

  row_t dir_tab [NUM_ROWS] = '{
    '{1'b0, 8'h41, 1'b1, 1'b1, KIND_CONTENT,   8'h41, 1'b0},
    '{1'b0, 8'h2C, 1'b1, 1'b1, KIND_FIELD_END, 8'h00, 1'b0},
    '{1'b0, 8'h0A, 1'b1, 1'b1, KIND_ROW_END,   8'h00, 1'b0},
    '{1'b0, 8'h0A, 1'b1, 1'b1, KIND_ROW_END,   8'h00, 1'b1},
    '{1'b0, 8'h0D, 1'b1, 1'b0, KIND_CONTENT,   8'h00, 1'b0},
    '{1'b0, 8'h00, 1'b1, 1'b1, KIND_CONTENT,   8'h00, 1'b0},
    '{1'b0, 8'hFF, 1'b1, 1'b1, KIND_CONTENT,   8'hFF, 1'b0},
    '{1'b0, 8'h22, 1'b1, 1'b0, KIND_CONTENT,   8'h00, 1'b0},
    '{1'b0, 8'h22, 1'b1, 1'b0, KIND_CONTENT,   8'h00, 1'b0},
    '{1'b0, 8'h22, 1'b1, 1'b1, KIND_CONTENT,   8'h22, 1'b0},
    '{1'b0, 8'h0A, 1'b1, 1'b1, KIND_CONTENT,   8'h0A, 1'b0},
    '{1'b0, 8'h22, 1'b1, 1'b0, KIND_CONTENT,   8'h00, 1'b0},
    '{1'b0, 8'h58, 1'b1, 1'b1, KIND_CONTENT,   8'h58, 1'b0},
    '{1'b1, 8'h00, 1'b1, 1'b1, KIND_ROW_END,   8'h00, 1'b0},
    '{1'b1, 8'hFF, 1'b1, 1'b0, KIND_CONTENT,   8'h00, 1'b0},
    '{1'b0, 8'hEF, 1'b1, 1'b0, KIND_CONTENT,   8'h00, 1'b0},
    '{1'b0, 8'hBB, 1'b1, 1'b0, KIND_CONTENT,   8'h00, 1'b0},
    '{1'b0, 8'hBF, 1'b1, 1'b0, KIND_CONTENT,   8'h00, 1'b0},
    '{1'b0, 8'h20, 1'b1, 1'b1, KIND_CONTENT,   8'h20, 1'b0},
    '{1'b0, 8'h0A, 1'b1, 1'b1, KIND_ROW_END,   8'h00, 1'b1},
    '{1'b1, 8'h00, 1'b1, 1'b0, KIND_CONTENT,   8'h00, 1'b0},
    '{1'b0, 8'hEF, 1'b0, 1'b0, KIND_CONTENT,   8'h00, 1'b0},
    '{1'b0, 8'hBB, 1'b0, 1'b0, KIND_CONTENT,   8'h00, 1'b0},
    '{1'b0, 8'h2C, 1'b0, 1'b0, KIND_CONTENT,   8'h00, 1'b0},
    '{1'b1, 8'h00, 1'b0, 1'b0, KIND_CONTENT,   8'h00, 1'b0},
    '{1'b0, 8'hEF, 1'b0, 1'b0, KIND_CONTENT,   8'h00, 1'b0},
    '{1'b1, 8'h00, 1'b0, 1'b0, KIND_CONTENT,   8'h00, 1'b0},
    '{1'b0, 8'h22, 1'b0, 1'b0, KIND_CONTENT,   8'h00, 1'b0}
  };

  csv_stream_tokenizer DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_content_byte (out_content_byte),
    .out_row_blank    (out_row_blank),
    .out_last         (out_last)
  );

  always #1 clk = ~clk;

  function automatic void parser_reset();
    pmode        = PM_PLAIN;
    bom_ph       = BOM_IDLE;
    fld_open     = 1'b0;
    row_open     = 1'b0;
    row_nonblank = 1'b0;
  endfunction

  function automatic void add_tok(kind_t k, logic [7:0] d, logic b);
    token_t t;
    if (step_toks.size() >= MAX_RES) return;
    t.kind  = k;
    t.data  = d;
    t.blank = b;
    t.last  = 1'b0;
    step_toks = {step_toks, t};
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  function automatic void put_content(logic [7:0] c);
    add_tok(KIND_CONTENT, c, 1'b0);
    fld_open = 1'b1;
    if (!is_blank(c)) row_nonblank = 1'b1;
  endfunction

  function automatic void close_row();
    add_tok(KIND_ROW_END, 8'h00, !row_nonblank);
    fld_open     = 1'b0;
    row_open     = 1'b0;
    row_nonblank = 1'b0;
  endfunction

  function automatic void parse_byte(logic [7:0] c);
    if (pmode == PM_QUOTE_SEEN) begin
      if (c == CH_QUOTE) begin
        put_content(c);
        pmode = PM_QUOTED;
        return;
      end
      pmode = PM_PLAIN;
    end
    if (pmode == PM_QUOTED) begin
      if (c == CH_QUOTE) pmode = PM_QUOTE_SEEN;
      else put_content(c);
      return;
    end
    pmode = PM_PLAIN;
    if (c == CH_QUOTE) begin
      pmode = PM_QUOTED;
    end else if (c == CH_COMMA) begin
      add_tok(KIND_FIELD_END, 8'h00, 1'b0);
      row_open = 1'b1;
      fld_open = 1'b0;
    end else if (c == CH_LF) begin
      close_row();
    end else if (c != CH_CR) begin
      put_content(c);
    end
  endfunction

  function automatic void replay_mark();
    if (bom_ph == BOM_HELD_EF) begin
      parse_byte(BOM_B0);
    end else if (bom_ph == BOM_HELD_EFBB) begin
      parse_byte(BOM_B0);
      parse_byte(BOM_B1);
    end
    bom_ph = BOM_DONE;
  endfunction

  function automatic void tokenize_item(logic act, logic [7:0] c);
    step_toks.delete();
    if (act) begin
      replay_mark();
      if (fld_open || row_open) close_row();
      parser_reset();
    end else begin
      case (bom_ph)
        BOM_IDLE: begin
          if (c == BOM_B0) bom_ph = BOM_HELD_EF;
          else begin
            bom_ph = BOM_DONE;
            parse_byte(c);
          end
        end
        BOM_HELD_EF: begin
          if (c == BOM_B1) bom_ph = BOM_HELD_EFBB;
          else begin
            replay_mark();
            parse_byte(c);
          end
        end
        BOM_HELD_EFBB: begin
          if (c == BOM_B2) bom_ph = BOM_DONE;
          else begin
            replay_mark();
            parse_byte(c);
          end
        end
        default: parse_byte(c);
      endcase
    end
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
  endfunction

  task automatic put_item(input logic act, input logic [7:0] c, input bit typed,
                          input bit exp_n, input token_t exp_tok);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 5)) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_data_byte <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tokenize_item(act, c);
    if (typed) begin
      if (exp_n) tokens_due = {tokens_due, exp_tok};
    end else begin
      foreach (step_toks[k]) tokens_due = {tokens_due, step_toks[k]};
    end
  endtask

  task automatic send(input logic act, input logic [7:0] c);
    put_item(act, c, 1'b0, 1'b0, '0);
    items_sent++;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_QUOTE || c == CH_COMMA || c == CH_CR || c == CH_LF);
    return c;
  endfunction

  task automatic stream_start();
    send(1'b1, 8'($urandom_range(0, 255)));
    case ($urandom_range(0, 3))
      0: begin
        send(1'b0, BOM_B0);
        send(1'b0, BOM_B1);
        send(1'b0, BOM_B2);
      end
      1: send(1'b0, BOM_B0);
      2: begin
        send(1'b0, BOM_B0);
        send(1'b0, BOM_B1);
      end
      default: ;
    endcase
  endtask

  task automatic csv_row();
    int nf;
    nf = $urandom_range(1, 4);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) send(1'b0, CH_COMMA);
      case ($urandom_range(0, 4))
        0: ;
        1: repeat ($urandom_range(1, 3)) send(1'b0, $urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        2: repeat ($urandom_range(1, 4)) send(1'b0, plain_byte());
        default: begin
          send(1'b0, CH_QUOTE);
          repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 5))
              0: begin
                send(1'b0, CH_QUOTE);
                send(1'b0, CH_QUOTE);
              end
              1: send(1'b0, CH_COMMA);
              2: send(1'b0, CH_LF);
              3: send(1'b0, CH_CR);
              default: send(1'b0, plain_byte());
            endcase
          end
          send(1'b0, CH_QUOTE);
        end
      endcase
    end
    case ($urandom_range(0, 9))
      0: send(1'b1, 8'($urandom_range(0, 255)));
      1, 2, 3: begin
        send(1'b0, CH_CR);
        send(1'b0, CH_LF);
      end
      default: send(1'b0, CH_LF);
    endcase
  endtask

  initial begin
    int stall_len;
    forever begin
      @(posedge clk);
      stall_len = 0;
      if (hold_req) begin
        stall_len = LONG_HOLD;
        hold_req  = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        stall_len = $urandom_range(1, 5);
      end
      if (stall_len > 0) begin
        out_ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    token_t t;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (tokens_due.size() == 0) begin
        $display("%0t: unexpected token kind %0d byte %02h blank %0b last %0b", $time,
                 out_kind, out_content_byte, out_row_blank, out_last);
        mismatches++;
      end else begin
        t = tokens_due.pop_front();
        if (out_kind !== t.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, t.kind, out_kind);
          mismatches++;
        end
        if (out_content_byte !== t.data) begin
          $display("%0t: content_byte expected %02h actual %02h", $time, t.data,
                   out_content_byte);
          mismatches++;
        end
        if (out_row_blank !== t.blank) begin
          $display("%0t: row_blank expected %0b actual %0b", $time, t.blank, out_row_blank);
          mismatches++;
        end
        if (out_last !== t.last) begin
          $display("%0t: last expected %0b actual %0b", $time, t.last, out_last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    token_t tok;
    bit hold_done;
    bit pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    parser_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      tok = '{kind: dir_tab[i].kind, data: dir_tab[i].d, blank: dir_tab[i].blank,
              last: 1'b1};
      put_item(dir_tab[i].act, dir_tab[i].c, dir_tab[i].typed, dir_tab[i].n, tok);
    end

    while (items_sent < RAND_ITEMS) begin
      idle_on = !(items_sent >= 180 && items_sent < 240) && items_sent < 430;
      if (items_sent >= 120 && !hold_done) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (items_sent >= 300 && !pause_done) begin
        in_valid <= 1'b0;
        wait (tokens_due.size() == 0);
        @(posedge clk);
        pause_done = 1'b1;
      end
      if ($urandom_range(0, 9) < 2) begin
        repeat ($urandom_range(1, 6))
          send($urandom_range(0, 19) == 0, 8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 4) == 0) stream_start();
        csv_row();
      end
    end
    in_valid <= 1'b0;

    wait (tokens_due.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
